// ===== hdl/rcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsc_pkg
// Types, codes and sizes shared by the ramp column stream checker.
// ----------------------------------------------------------------------------
package rcsc_pkg;

  localparam int MAX_ROW_WORDS  = 1024;
  localparam int POS_W          = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
  localparam int ROW_COUNT_BITS = 48;
  localparam int Q_DEPTH        = 4;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] RUN_MAX       = 3'd7;
  localparam logic [2:0] LOG_RUN_BOUND = 3'd5;

  // Input opcodes and result kinds.
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ROW_WORDS    = 3'd0;
  localparam logic [2:0] CFG_COUNT_COLUMN = 3'd1;
  localparam logic [2:0] CFG_RAMP_STEP    = 3'd2;
  localparam logic [2:0] CFG_SWAP_BYTES   = 3'd3;
  localparam logic [2:0] CFG_SKIP_ROWS    = 3'd4;
  localparam logic [2:0] CFG_ERROR_LIMIT  = 3'd5;

  typedef struct packed {
    logic [10:0] row_words;
    logic [9:0]  count_column;
    logic [31:0] ramp_step;
    logic        swap_bytes;
    logic [31:0] skip_rows;
    logic [31:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic                      result_kind;
    logic                      mismatch;
    logic                      log_this;
    logic [2:0]                run_length;
    logic [ROW_COUNT_BITS-1:0] row_index;
    logic [31:0]               previous_value;
    logic [31:0]               actual_value;
    logic [31:0]               total_errors;
    logic                      limit_reached;
    logic [31:0]               clean_reports;
    logic [31:0]               dirty_intervals;
    logic                      ever_dirty;
  } out_item_t;

  // Classified work item passed from the front end to the back end.
  typedef struct packed {
    logic                      kind;
    logic                      match;
    logic                      skip;
    logic [ROW_COUNT_BITS-1:0] row_index;
    logic [31:0]               prev;
    logic [31:0]               actual;
  } work_t;

endpackage

// ===== hdl/rcsc_front.sv =====
// ----------------------------------------------------------------------------
// rcsc_front
// Tracks the row position, captures the counter word and classifies each
// row end or tick into a work item with the ramp comparison already done.
// ----------------------------------------------------------------------------
module rcsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rcsc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  rcsc_pkg::in_item_t in_item,
  output logic              push,
  output rcsc_pkg::work_t    work
);
  import rcsc_pkg::*;

  logic [POS_W-1:0]          word_pos_r, word_pos_nxt;
  logic [31:0]               captured_r, captured_nxt;
  logic [31:0]               last_r, last_nxt;
  logic [ROW_COUNT_BITS-1:0] row_cnt_r, row_cnt_nxt;

  logic [31:0]      len_eff;
  logic [POS_W-1:0] last_pos;
  logic [31:0]      cap_now;
  logic [31:0]      actual;
  logic             row_end;

  function automatic logic [31:0] byte_reverse(input logic [31:0] v);
    byte_reverse = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  always_comb begin
    if (cfg.row_words == 11'd0) begin
      len_eff = 32'd1;
    end else if (32'(cfg.row_words) > 32'(MAX_ROW_WORDS)) begin
      len_eff = 32'(MAX_ROW_WORDS);
    end else begin
      len_eff = 32'(cfg.row_words);
    end
    last_pos = POS_W'(len_eff - 32'd1);

    cap_now = (word_pos_r == '0) ? 32'd0 : captured_r;
    if (32'(word_pos_r) == 32'(cfg.count_column)) begin
      cap_now = in_item.data_word;
    end
    actual = cfg.swap_bytes ? byte_reverse(cap_now) : cap_now;
    // A lowered row length ends the row at once when the position is past it.
    row_end = (word_pos_r >= last_pos);

    word_pos_nxt = word_pos_r;
    captured_nxt = captured_r;
    last_nxt     = last_r;
    row_cnt_nxt  = row_cnt_r;
    push         = 1'b0;
    work         = '0;

    if (in_valid) begin
      if (in_item.opcode == OP_TICK) begin
        push           = 1'b1;
        work.kind      = KIND_TICK;
        work.row_index = row_cnt_r;
        work.prev      = last_r;
      end else if (!row_end) begin
        word_pos_nxt = word_pos_r + POS_W'(1);
        captured_nxt = cap_now;
      end else begin
        push           = 1'b1;
        work.kind      = KIND_CHECK;
        work.match     = (actual == last_r + cfg.ramp_step);
        work.skip      = (ROW_COUNT_BITS'(cfg.skip_rows) > row_cnt_r);
        work.row_index = row_cnt_r;
        work.prev      = last_r;
        work.actual    = actual;
        word_pos_nxt   = '0;
        captured_nxt   = cap_now;
        last_nxt       = actual;
        row_cnt_nxt    = row_cnt_r + ROW_COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_pos_r <= '0;
      captured_r <= '0;
      last_r     <= '0;
      row_cnt_r  <= '0;
    end else begin
      word_pos_r <= word_pos_nxt;
      captured_r <= captured_nxt;
      last_r     <= last_nxt;
      row_cnt_r  <= row_cnt_nxt;
    end
  end

endmodule

// ===== hdl/rcsc_queue.sv =====
// ----------------------------------------------------------------------------
// rcsc_queue
// Short first-in first-out queue of work items between front and back end.
// ----------------------------------------------------------------------------
module rcsc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rcsc_pkg::work_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output rcsc_pkg::work_t  head
);
  import rcsc_pkg::*;

  work_t                slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= Q_DEPTH)
    else $error("queue count exceeds its depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || 32'(count_r) == Q_DEPTH) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with the count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r != '0))
    else $error("queue lost an item on push");
`endif

endmodule

// ===== hdl/rcsc_back.sv =====
// ----------------------------------------------------------------------------
// rcsc_back
// Carries out classified work items: error totals, runs, the error limit
// and interval counts, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rcsc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rcsc_pkg::cfg_t     cfg,
  input  logic              q_not_empty,
  input  rcsc_pkg::work_t    q_head,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output rcsc_pkg::out_item_t out_data
);
  import rcsc_pkg::*;

  logic [31:0] total_r, total_nxt;
  logic [2:0]  run_r, run_nxt;
  logic [31:0] at_tick_r, at_tick_nxt;
  logic [31:0] clean_r, clean_nxt;
  logic [31:0] dirty_r, dirty_nxt;
  logic        seen_r, seen_nxt;
  logic        halted_r, halted_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r;
  out_item_t   res;
  logic        produce;
  logic        taken;
  logic [31:0] limit_m1;

  assign taken     = out_pop && out_valid_r;
  assign q_pop     = q_not_empty && (!out_valid_r || taken);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign limit_m1  = cfg.error_limit - 32'd1;

  always_comb begin
    total_nxt   = total_r;
    run_nxt     = run_r;
    at_tick_nxt = at_tick_r;
    clean_nxt   = clean_r;
    dirty_nxt   = dirty_r;
    seen_nxt    = seen_r;
    halted_nxt  = halted_r;
    produce     = 1'b0;
    res         = '0;

    // Once stopped, queued items are drained without a result.
    if (q_pop && !halted_r) begin
      produce            = 1'b1;
      res.row_index      = q_head.row_index;
      res.previous_value = q_head.prev;
      if (q_head.kind == KIND_TICK) begin
        res.result_kind = KIND_TICK;
        if (total_r > at_tick_r) begin
          dirty_nxt = dirty_r + 32'd1;
          seen_nxt  = 1'b1;
        end else begin
          clean_nxt = clean_r + 32'd1;
        end
        at_tick_nxt = total_r;
      end else begin
        res.result_kind  = KIND_CHECK;
        res.actual_value = q_head.actual;
        if (q_head.match) begin
          run_nxt = '0;
        end else if (!q_head.skip) begin
          res.mismatch = 1'b1;
          total_nxt    = (total_r == '1) ? total_r : total_r + 32'd1;
          run_nxt      = (run_r == RUN_MAX) ? run_r : run_r + 3'd1;
          res.log_this = (run_nxt < LOG_RUN_BOUND);
          if (cfg.error_limit != '0 && total_r >= limit_m1) begin
            halted_nxt = 1'b1;
          end
        end
        res.limit_reached = halted_nxt;
      end
      res.run_length      = run_nxt;
      res.total_errors    = total_nxt;
      res.clean_reports   = clean_nxt;
      res.dirty_intervals = dirty_nxt;
      res.ever_dirty      = seen_nxt;
    end

    out_valid_nxt = produce ? 1'b1 : (taken ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      run_r       <= '0;
      at_tick_r   <= '0;
      clean_r     <= '0;
      dirty_r     <= '0;
      seen_r      <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      run_r       <= run_nxt;
      at_tick_r   <= at_tick_nxt;
      clean_r     <= clean_nxt;
      dirty_r     <= dirty_nxt;
      seen_r      <= seen_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_r <= res;
    end
  end

`ifndef ASSERT_OFF
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> !$rose(out_valid_r))
    else $error("result produced after the block stopped");

  a_log_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.mismatch || !out_r.log_this))
    else $error("log flag set without a mismatch");

  a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (total_r >= $past(total_r)))
    else $error("error total decreased");

  a_halt_needs_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> (total_r != '0))
    else $error("block stopped without any counted error");
`endif

endmodule

// ===== hdl/ramp_column_stream_checker.sv =====
// ----------------------------------------------------------------------------
// ramp_column_stream_checker
// Checks a ramp counter held at one column of each row of a word stream.
//
//   Channel   Ports                          Transfer when
//   input     in_push, in_full, in_data      in_push && !in_full
//   result    out_empty, out_pop, out_data   out_pop && !out_empty
//   config    cfg_we, cfg_index, cfg_wdata   cfg_we
//
// One item is taken per cycle while the work queue is not full; the front
// end classifies each item in the same cycle as the edge that takes it and
// writes the four-entry work queue, and the back end then moves the head
// into the output register once that register is free. Words inside a row
// and items after the error limit stops the block give no result. Reset is
// synchronous and clears all counters; the input side keeps taking
// transfers while a result waits, until the work queue fills.
// ----------------------------------------------------------------------------
module ramp_column_stream_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  rcsc_pkg::in_item_t   in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output rcsc_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import rcsc_pkg::*;

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  f_push;
  work_t f_work;
  work_t q_head;

  assign in_full = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_words    <= 11'd104;
      cfg_r.count_column <= 10'd96;
      cfg_r.ramp_step    <= 32'd1;
      cfg_r.swap_bytes   <= 1'b0;
      cfg_r.skip_rows    <= 32'd0;
      cfg_r.error_limit  <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_WORDS:    cfg_r.row_words    <= cfg_wdata[10:0];
        CFG_COUNT_COLUMN: cfg_r.count_column <= cfg_wdata[9:0];
        CFG_RAMP_STEP:    cfg_r.ramp_step    <= cfg_wdata;
        CFG_SWAP_BYTES:   cfg_r.swap_bytes   <= cfg_wdata[0];
        CFG_SKIP_ROWS:    cfg_r.skip_rows    <= cfg_wdata;
        CFG_ERROR_LIMIT:  cfg_r.error_limit  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rcsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_push && !q_full),
    .in_item  (in_data),
    .push     (f_push),
    .work     (f_work)
  );

  rcsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_work),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rcsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ramp column stream checker testbench
// Streams rows of words into the checker and scores every result against
// a behavioural predictor kept in step with each accepted transfer. Covers
// ramp wrap, error runs, byte swap, row length limits, skipped rows,
// interval ticks, a full work queue, randomised register settings with
// mostly intact ramps, the longest row and the stop on the error limit.
// ----------------------------------------------------------------------------
module testbench;
  import rcsc_pkg::*;

  localparam int IDLE_SETTLE = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  logic      in_full;
  in_item_t  in_data   = '0;
  logic      out_empty;
  logic      out_pop   = 1'b0;
  out_item_t out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_ROW_WORDS;
  logic [31:0] cfg_wdata = '0;

  // Register copies as seen by the predictor.
  logic [10:0] cfg_rows  = 11'd104;
  logic [9:0]  cfg_col   = 10'd96;
  logic [31:0] cfg_step  = 32'd1;
  logic        cfg_swap  = 1'b0;
  logic [31:0] cfg_skip  = '0;
  logic [31:0] cfg_limit = '0;

  // Checker state as seen by the predictor.
  int unsigned word_pos      = 0;
  logic [47:0] row_cnt       = '0;
  logic [31:0] last_ctr      = '0;
  logic [31:0] err_total     = '0;
  logic [2:0]  err_run       = '0;
  logic [31:0] errs_at_tick  = '0;
  logic [31:0] clean_cnt     = '0;
  logic [31:0] dirty_cnt     = '0;
  logic        dirty_flag    = 1'b0;
  logic        stopped       = 1'b0;
  logic [31:0] captured_word = '0;

  out_item_t   results_due[$];
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned hold_request  = 0;
  bit          tx_gaps_on    = 1'b1;
  bit          rx_gaps_on    = 1'b1;

  ramp_column_stream_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic int unsigned row_length();
    int unsigned n;
    n = cfg_rows;
    if (n == 0) n = 1;
    if (n > MAX_ROW_WORDS) n = MAX_ROW_WORDS;
    return n;
  endfunction

  function automatic int unsigned tx_gap();
    return tx_gaps_on ? $urandom_range(10, 0) : 0;
  endfunction

  // Works out the result, if any, that one accepted item causes.
  function automatic void predict_ramp_result(input in_item_t item);
    out_item_t   r;
    int unsigned len;
    logic [31:0] actual;
    logic [31:0] prev;
    logic [47:0] idx;
    if (stopped) return;
    r = '0;
    if (item.opcode == OP_TICK) begin
      if (err_total > errs_at_tick) begin
        dirty_cnt++;
        dirty_flag = 1'b1;
      end else begin
        clean_cnt++;
      end
      errs_at_tick = err_total;
      r.result_kind    = KIND_TICK;
      r.row_index      = row_cnt;
      r.previous_value = last_ctr;
    end else begin
      len = row_length();
      if (word_pos == 0) captured_word = '0;
      if (word_pos == cfg_col) captured_word = item.data_word;
      if (word_pos + 1 < len) begin
        word_pos++;
        return;
      end
      word_pos = 0;
      actual = cfg_swap ? swap32(captured_word) : captured_word;
      prev   = last_ctr;
      idx    = row_cnt;
      r.result_kind = KIND_CHECK;
      if (actual == prev + cfg_step) begin
        err_run = '0;
      end else if (idx >= {16'h0, cfg_skip}) begin
        r.mismatch = 1'b1;
        if (err_total != 32'hFFFF_FFFF) err_total++;
        if (err_run != RUN_MAX) err_run++;
        r.log_this = (err_run < LOG_RUN_BOUND);
        if (cfg_limit != 0 && err_total >= cfg_limit) stopped = 1'b1;
      end
      last_ctr = actual;
      row_cnt++;
      r.row_index      = idx;
      r.previous_value = prev;
      r.actual_value   = actual;
      r.limit_reached  = stopped;
    end
    r.run_length      = err_run;
    r.total_errors    = err_total;
    r.clean_reports   = clean_cnt;
    r.dirty_intervals = dirty_cnt;
    r.ever_dirty      = dirty_flag;
    results_due.push_back(r);
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      fail_count++;
      $display("%0t: result expected none actual %h", $time, got);
      return;
    end
    want = results_due.pop_front();
    compare_field("result_kind", want.result_kind, got.result_kind);
    compare_field("mismatch", want.mismatch, got.mismatch);
    compare_field("log_this", want.log_this, got.log_this);
    compare_field("run_length", want.run_length, got.run_length);
    compare_field("row_index", want.row_index, got.row_index);
    compare_field("previous_value", want.previous_value, got.previous_value);
    compare_field("actual_value", want.actual_value, got.actual_value);
    compare_field("total_errors", want.total_errors, got.total_errors);
    compare_field("limit_reached", want.limit_reached, got.limit_reached);
    compare_field("clean_reports", want.clean_reports, got.clean_reports);
    compare_field("dirty_intervals", want.dirty_intervals, got.dirty_intervals);
    compare_field("ever_dirty", want.ever_dirty, got.ever_dirty);
  endtask

  // Result side: takes each transfer, then stalls for a drawn number of
  // cycles, or for a long hold when a test asks for one.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        check_result(out_data);
        stall = rx_gaps_on ? $urandom_range(10, 0) : 0;
      end
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Offers one item after a gap and returns at the edge that takes it.
  // Push is left high so that back-to-back items are offered without a break.
  task automatic send_item(input in_item_t item, input int unsigned gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full !== 1'b0);
    items_sent++;
    predict_ramp_result(item);
  endtask

  task automatic send_op(input logic op, input logic [31:0] word);
    in_item_t item;
    item.opcode    = op;
    item.data_word = word;
    send_item(item, tx_gap());
  endtask

  // Sends the rest of the current row with the counter at its column,
  // either continuing the ramp or corrupted. Ticks may fall between words.
  task automatic send_row(input bit intact, input int unsigned tick_pct);
    int unsigned len;
    int unsigned start;
    int unsigned words;
    logic [31:0] counter_word;
    len   = row_length();
    start = word_pos;
    words = (start + 1 >= len) ? 1 : len - start;
    counter_word = last_ctr + cfg_step;
    if (cfg_swap) counter_word = swap32(counter_word);
    if (!intact) begin
      if ($urandom_range(1, 0) == 0) counter_word ^= 32'h1 << $urandom_range(31, 0);
      else counter_word = $urandom;
    end
    for (int k = 0; k < words; k++) begin
      if ($urandom_range(99, 0) < tick_pct) send_op(OP_TICK, $urandom);
      send_op(OP_DATA, (start + k == cfg_col) ? counter_word : $urandom);
    end
  endtask

  // Drains all pending results, then lets words still in flight settle.
  task automatic wait_idle();
    int unsigned waited;
    in_push <= 1'b0;
    waited = 0;
    while (results_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Registers are only written with the input idle and the queue drained.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_ROW_WORDS:    cfg_rows  = val[10:0];
      CFG_COUNT_COLUMN: cfg_col   = val[9:0];
      CFG_RAMP_STEP:    cfg_step  = val;
      CFG_SWAP_BYTES:   cfg_swap  = val[0];
      CFG_SKIP_ROWS:    cfg_skip  = val;
      CFG_ERROR_LIMIT:  cfg_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [31:0] rows, input logic [31:0] col,
                               input logic [31:0] step, input logic [31:0] swap,
                               input logic [31:0] skip, input logic [31:0] limit);
    write_reg(CFG_ROW_WORDS, rows);
    write_reg(CFG_COUNT_COLUMN, col);
    write_reg(CFG_RAMP_STEP, step);
    write_reg(CFG_SWAP_BYTES, swap);
    write_reg(CFG_SKIP_ROWS, skip);
    write_reg(CFG_ERROR_LIMIT, limit);
  endtask

  // One-word rows: first row against zero, wrap of the ramp, a run of
  // errors that saturates, and dirty then clean intervals.
  task automatic test_ramp_wrap_and_runs();
    wait_idle();
    set_registers(1, 0, 1, 0, 0, 0);
    send_op(OP_DATA, 32'h0000_0001);
    send_op(OP_DATA, 32'hFFFF_FFFF);
    send_op(OP_DATA, 32'h0000_0000);
    send_op(OP_TICK, 32'h0000_0000);
    send_op(OP_TICK, 32'hFFFF_FFFF);
    repeat (8) send_op(OP_DATA, 32'hA5A5_A5A5);
    send_op(OP_TICK, 32'h5A5A_5A5A);
  endtask

  // Byte swap, extreme steps, row length of zero, the counter column
  // beyond the row and a row cut short by a lower row length.
  task automatic test_swap_and_row_limits();
    wait_idle();
    write_reg(CFG_SWAP_BYTES, 1);
    write_reg(CFG_RAMP_STEP, 32'h0100_0000);
    send_op(OP_DATA, swap32(last_ctr + cfg_step));
    write_reg(CFG_RAMP_STEP, 32'hFFFF_FFFF);
    send_op(OP_DATA, swap32(last_ctr + cfg_step));
    write_reg(CFG_ROW_WORDS, 0);
    write_reg(CFG_SWAP_BYTES, 0);
    write_reg(CFG_RAMP_STEP, 0);
    send_op(OP_DATA, last_ctr);
    write_reg(CFG_ROW_WORDS, 2);
    write_reg(CFG_COUNT_COLUMN, 1023);
    send_op(OP_DATA, $urandom);
    send_op(OP_DATA, $urandom);
    write_reg(CFG_ROW_WORDS, 3);
    write_reg(CFG_COUNT_COLUMN, 1);
    send_op(OP_DATA, $urandom);
    send_op(OP_DATA, last_ctr);
    wait_idle();
    write_reg(CFG_ROW_WORDS, 2);
    send_op(OP_DATA, $urandom);
  endtask

  // Errors in rows below the skip count are not counted.
  task automatic test_skipped_rows();
    wait_idle();
    set_registers(1, 0, 1, 0, row_cnt[31:0] + 2, 32'hFFFF_FFFF);
    repeat (3) send_op(OP_DATA, 32'h5A5A_5A5A);
    send_op(OP_DATA, last_ctr + 1);
  endtask

  // The result side holds off while items keep coming, so the block fills.
  task automatic test_backpressure();
    wait_idle();
    set_registers(1, 0, 1, 0, 0, 0);
    tx_gaps_on   = 1'b0;
    hold_request = 80;
    repeat (30) send_row($urandom_range(3, 0) != 0, 10);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int unsigned phase_end;
    int unsigned len;
    logic [31:0] rows, col, step, skip, limit;
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      tx_gaps_on = $urandom_range(1, 0);
      rx_gaps_on = $urandom_range(1, 0);
      if (p == 0) begin
        set_registers(104, 96, 1, 0, 0, 0);
      end else begin
        case ($urandom_range(3, 0))
          0:       rows = 0;
          1:       rows = 1;
          default: rows = $urandom_range(12, 2);
        endcase
        len = (rows == 0) ? 1 : rows;
        case ($urandom_range(9, 0))
          0:       col = 1023;
          1:       col = $urandom_range(1023, 0);
          default: col = $urandom_range(len - 1, 0);
        endcase
        case ($urandom_range(4, 0))
          0:       step = 0;
          1:       step = 1;
          2:       step = 32'hFFFF_FFFF;
          default: step = $urandom;
        endcase
        case ($urandom_range(5, 0))
          0:       skip = row_cnt[31:0] + $urandom_range(20, 1);
          1:       skip = 32'hFFFF_FFFF;
          default: skip = 0;
        endcase
        case ($urandom_range(2, 0))
          0:       limit = 0;
          1:       limit = 32'hFFFF_FFFF;
          default: limit = err_total + 5000 + $urandom_range(1000, 0);
        endcase
        set_registers(rows, col, step, $urandom_range(1, 0), skip, limit);
      end
      phase_end = items_sent + 45;
      while (items_sent < phase_end) send_row($urandom_range(99, 0) < 85, 5);
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // A row length above the maximum acts as the maximum; counter in the
  // last column.
  task automatic test_longest_row();
    wait_idle();
    tx_gaps_on = 1'b0;
    set_registers(11'h7FF, 1023, $urandom, 1, 0, 32'hFFFF_FFFF);
    send_row(1'b1, 0);
    tx_gaps_on = 1'b1;
  endtask

  // A limit below the total stops the block at the next counted error;
  // afterwards every item is ignored, even once the limit is cleared.
  task automatic test_error_limit_stop();
    wait_idle();
    set_registers(1, 0, 1, 0, 0, 1);
    send_op(OP_DATA, last_ctr + 1);
    send_op(OP_DATA, last_ctr + 2);
    send_op(OP_TICK, $urandom);
    send_op(OP_DATA, last_ctr + 1);
    wait_idle();
    write_reg(CFG_ERROR_LIMIT, 0);
    send_op(OP_TICK, $urandom);
    send_op(OP_DATA, $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ramp_wrap_and_runs();
    test_swap_and_row_limits();
    test_skipped_rows();
    test_backpressure();
    test_random_phases();
    test_longest_row();
    test_error_limit_stop();
    wait_idle();
    if (results_due.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results expected actual none", $time, results_due.size());
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
